// ----- design/zsce_pkg.sv -----
// Shared types and constants for the zoomed sprite chunk expander.
// Used by the channel interfaces, the address fold unit, the top level and the checker.
// No dependencies.
package zsce_pkg;

  localparam int MAP_WORDS_DEF = 32768;

  localparam int ADDR_W  = 15;
  localparam int DATA_W  = 16;
  localparam int CODE_W  = 15;
  localparam int COLS    = 8;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  localparam logic [8:0]  DEAD_Y    = 9'h180;
  localparam logic [9:0]  WRAP_LIM  = 10'h140;
  localparam logic [9:0]  WRAP_SPAN = 10'h200;
  localparam int          Y_BIAS    = 3;
  localparam int          ZOOM_FULL = 128;

  localparam logic [15:0] PRIO_MASK_LO = 16'hff00;
  localparam logic [15:0] PRIO_MASK_HI = 16'hfffc;

  // Reciprocal reduction of a map address modulo the map size.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam int QUOT_W      = 9;
  localparam int MOD_W       = 17;

  typedef struct packed {
    logic              vld;
    logic              wr;
    logic [DATA_W-1:0] data;
    logic [COL_W-1:0]  col;
  } fold_tag_t;

endpackage

// ----- design/zsce_chan_if.sv -----
// Valid/ready channel interfaces for the draw and write items and the chunk commands.
// Depends on zsce_pkg.
interface zsce_in_if;
  import zsce_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] map_addr;
  logic [DATA_W-1:0] map_data;
  logic [15:0]       attr_word0;
  logic [15:0]       attr_word1;
  logic [15:0]       attr_word2;
  logic [15:0]       attr_word3;
  logic [ROW_W-1:0]  row_index;

  modport source (
    output valid, cmd, map_addr, map_data, attr_word0, attr_word1, attr_word2,
    output attr_word3, row_index,
    input  ready
  );
  modport sink (
    input  valid, cmd, map_addr, map_data, attr_word0, attr_word1, attr_word2,
    input  attr_word3, row_index,
    output ready
  );
endinterface

interface zsce_out_if;
  import zsce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] chunk_code;
  logic [7:0]        chunk_color;
  logic              flip_x;
  logic              flip_y;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic [4:0]        zoom_width;
  logic [3:0]        zoom_height;
  logic [15:0]       priority_mask;
  logic              last_chunk;

  modport source (
    output valid, chunk_code, chunk_color, flip_x, flip_y, screen_x, screen_y,
    output zoom_width, zoom_height, priority_mask, last_chunk,
    input  ready
  );
  modport sink (
    input  valid, chunk_code, chunk_color, flip_x, flip_y, screen_x, screen_y,
    input  zoom_width, zoom_height, priority_mask, last_chunk,
    output ready
  );
endinterface

// ----- design/zsce_addr_fold.sv -----
// Two-stage unit that reduces a 15-bit map address modulo the map size.
// A reciprocal multiply estimates the quotient; one compare and subtract corrects it.
// Depends on zsce_pkg.
module zsce_addr_fold #(
  parameter int MAP_WORDS = zsce_pkg::MAP_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  zsce_pkg::fold_tag_t                req_tag,
  input  logic [zsce_pkg::ADDR_W-1:0]        req_addr,
  output zsce_pkg::fold_tag_t                rsp_tag,
  output logic [$clog2(MAP_WORDS)-1:0]       rsp_addr
);
  import zsce_pkg::*;

  localparam int AW     = $clog2(MAP_WORDS);
  localparam int PROD_W = ADDR_W + RECIP_W;
  localparam int QM_W   = QUOT_W + MOD_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / MAP_WORDS);
  localparam logic [MOD_W-1:0]   MOD   = MOD_W'(MAP_WORDS);

  fold_tag_t          tag1_r;
  logic [ADDR_W-1:0]  addr1_r;
  logic [QUOT_W-1:0]  quot1_r;
  fold_tag_t          tag2_r;
  logic [AW-1:0]      addr2_r;

  logic [PROD_W-1:0]  prod;
  logic [QM_W-1:0]    qm;
  logic [MOD_W-1:0]   rem;
  logic [MOD_W-1:0]   rem_fix;

  assign prod    = PROD_W'(req_addr) * PROD_W'(RECIP);
  assign qm      = QM_W'(quot1_r) * QM_W'(MOD);
  assign rem     = MOD_W'(QM_W'(addr1_r) - qm);
  assign rem_fix = (rem >= MOD) ? (rem - MOD) : rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= req_tag;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    addr1_r <= req_addr;
    quot1_r <= QUOT_W'(prod >> RECIP_SHIFT);
    addr2_r <= AW'(rem_fix);
  end

  assign rsp_tag  = tag2_r;
  assign rsp_addr = addr2_r;

endmodule

// ----- design/zoomed_sprite_chunk_expander.sv -----
// Top level of the zoomed sprite chunk expander: chunk map memory, row sequencer, output stage.
// Depends on zsce_pkg, zsce_chan_if and zsce_addr_fold.
//
//   Channel   Direction  Handshake      Carries
//   in_chan   in         valid/ready    map write or sprite row draw item
//   out_chan  out        valid/ready    one chunk draw command
//
// A write or a dead sprite leaves the input ready.
// A draw item issues eight map reads, one per cycle, through the two-stage address fold
// and the registered map read, then emits one command per valid chunk, waiting while
// the output is stalled.
// Reset is synchronous; the chunk map itself is not cleared.
module zoomed_sprite_chunk_expander #(
  parameter int MAP_WORDS = zsce_pkg::MAP_WORDS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  zsce_in_if.sink   in_chan,
  zsce_out_if.source out_chan
);
  import zsce_pkg::*;

  localparam int AW = $clog2(MAP_WORDS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] map_mem [MAP_WORDS];

  // Sprite fields held for the row.
  logic              fx_r, fy_r, prio_r;
  logic [7:0]        color_r;
  logic [7:0]        tile_r;
  logic [ROW_W-1:0]  py_r;
  logic [7:0]        zx_r;
  logic [9:0]        x_r;
  logic [9:0]        cy_r;
  logic [3:0]        hgt_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CODE_W-1:0] code_buf_r [COLS];
  logic [COLS-1:0]   pend_r;

  fold_tag_t         fold_req;
  logic [ADDR_W-1:0] fold_addr;
  fold_tag_t         fold_rsp;
  logic [AW-1:0]     fold_rsp_addr;

  logic              rd_vld_r;
  logic [COL_W-1:0]  rd_col_r;
  logic [DATA_W-1:0] rd_data_r;

  logic              accept;
  logic              is_dead;

  // Decode of the incoming sprite entry.
  logic [7:0]        zy;
  logic [8:0]        xin;
  logic [9:0]        x_dec;
  logic [9:0]        y_raw;
  logic [9:0]        y_dec;
  logic [11:0]       ry;
  logic [11:0]       ry1;

  // Chunk selection and command build.
  logic [COL_W-1:0]  pick;
  logic [COLS-1:0]   pend_rest;
  logic [10:0]       kx;
  logic [10:0]       k1x;
  logic              load;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic [7:0]        out_color_r;
  logic              out_fx_r, out_fy_r;
  logic [9:0]        out_x_r, out_y_r;
  logic [4:0]        out_w_r;
  logic [3:0]        out_h_r;
  logic [15:0]       out_prio_r;
  logic              out_last_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_dead       = (in_chan.attr_word0[8:0] == DEAD_Y);

  assign zy    = 8'(in_chan.attr_word0[15:9]) + 8'd1;
  assign xin   = in_chan.attr_word2[8:0];
  assign x_dec = (10'(xin) > WRAP_LIM) ? (10'(xin) - WRAP_SPAN) : 10'(xin);
  assign y_raw = 10'(in_chan.attr_word0[8:0]) + 10'(Y_BIAS) + 10'(ZOOM_FULL) - 10'(zy);
  assign y_dec = (y_raw > WRAP_LIM) ? (y_raw - WRAP_SPAN) : y_raw;
  assign ry    = 12'(in_chan.row_index) * 12'(zy);
  assign ry1   = ry + 12'(zy);

  always_ff @(posedge clk) begin
    if (accept) begin
      fx_r    <= in_chan.attr_word2[14];
      fy_r    <= in_chan.attr_word1[15];
      prio_r  <= in_chan.attr_word2[15];
      color_r <= in_chan.attr_word3[15:8];
      tile_r  <= in_chan.attr_word3[7:0];
      py_r    <= in_chan.attr_word1[15] ? ~in_chan.row_index : in_chan.row_index;
      zx_r    <= 8'(in_chan.attr_word1[6:0]) + 8'd1;
      x_r     <= x_dec;
      cy_r    <= y_dec + 10'(ry >> 4);
      hgt_r   <= 4'((ry1 >> 4) - (ry >> 4));
    end
  end

  // Writes enter the fold directly from the input; reads are issued by the sequencer.
  always_comb begin
    fold_req  = '0;
    fold_addr = '0;
    if (accept && (in_chan.cmd == CMD_WRITE)) begin
      fold_req.vld  = 1'b1;
      fold_req.wr   = 1'b1;
      fold_req.data = in_chan.map_data;
      fold_addr     = in_chan.map_addr;
    end else if (state_r == ST_ISSUE) begin
      fold_req.vld = 1'b1;
      fold_req.col = col_r;
      fold_addr    = {tile_r, py_r, (fx_r ? ~col_r : col_r)};
    end
  end

  zsce_addr_fold #(
    .MAP_WORDS (MAP_WORDS)
  ) u_addr_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_tag  (fold_req),
    .req_addr (fold_addr),
    .rsp_tag  (fold_rsp),
    .rsp_addr (fold_rsp_addr)
  );

  always_ff @(posedge clk) begin
    if (fold_rsp.vld && fold_rsp.wr) begin
      map_mem[fold_rsp_addr] <= fold_rsp.data;
    end
    rd_data_r <= map_mem[fold_rsp_addr];
    rd_col_r  <= fold_rsp.col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= fold_rsp.vld && !fold_rsp.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      code_buf_r[rd_col_r] <= rd_data_r[CODE_W-1:0];
    end
  end

  always_comb begin
    pick = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick = COL_W'(i);
      end
    end
  end

  assign pend_rest = pend_r & ~(COLS'(1) << pick);
  assign load      = (state_r == ST_EMIT) && (|pend_r) && (!out_valid_r || out_chan.ready);
  assign kx        = 11'(pick) * 11'(zx_r);
  assign k1x       = kx + 11'(zx_r);

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    unique case (state_r)
      ST_IDLE: begin
        col_nxt = '0;
        if (accept && (in_chan.cmd == CMD_DRAW) && !is_dead) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        col_nxt = col_r + COL_W'(1);
        if (col_r == COL_W'(COLS - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rd_vld_r && (rd_col_r == COL_W'(COLS - 1))) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!(|pend_r) || (load && !(|pend_rest))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      if (rd_vld_r) begin
        pend_r[rd_col_r] <= ~rd_data_r[DATA_W-1];
      end else if (load) begin
        pend_r <= pend_rest;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code_r  <= code_buf_r[pick];
      out_color_r <= color_r;
      out_fx_r    <= fx_r;
      out_fy_r    <= fy_r;
      out_x_r     <= x_r + 10'(kx >> 3);
      out_y_r     <= cy_r;
      out_w_r     <= 5'((k1x >> 3) - (kx >> 3));
      out_h_r     <= hgt_r;
      out_prio_r  <= prio_r ? PRIO_MASK_HI : PRIO_MASK_LO;
      out_last_r  <= !(|pend_rest);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.chunk_code    = out_code_r;
  assign out_chan.chunk_color   = out_color_r;
  assign out_chan.flip_x        = out_fx_r;
  assign out_chan.flip_y        = out_fy_r;
  assign out_chan.screen_x      = signed'(out_x_r);
  assign out_chan.screen_y      = signed'(out_y_r);
  assign out_chan.zoom_width    = out_w_r;
  assign out_chan.zoom_height   = out_h_r;
  assign out_chan.priority_mask = out_prio_r;
  assign out_chan.last_chunk    = out_last_r;

endmodule

// ----- design/zsce_checker.sv -----
// Port-level checker for the zoomed sprite chunk expander, bound to the top level.
// Depends on zsce_pkg and the top level's channel ports.
module zsce_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_cmd,
  input logic [15:0]                 in_attr_word0,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [zsce_pkg::CODE_W-1:0] out_code,
  input logic                        out_last
);
  import zsce_pkg::*;

  logic in_acc;
  logic dead;

  assign in_acc = in_valid && in_ready;
  assign dead   = (in_attr_word0[8:0] == DEAD_Y);

  // A write or a dead sprite produces no command and leaves the block ready.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ((in_cmd == CMD_WRITE) || dead) |=> in_ready && !$rose(out_valid))
    else $error("write or dead sprite produced a command");

  // A live draw transaction keeps the input closed while the row is expanded.
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == CMD_DRAW) && !dead |=> !in_ready)
    else $error("input reopened during row expansion");

  // While idle, any command still waiting must be the last of its row.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("idle with a non-final command pending");

  // A stalled command holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_last))
    else $error("stalled command changed");

endmodule

bind zoomed_sprite_chunk_expander zsce_checker u_zsce_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_cmd        (in_chan.cmd),
  .in_attr_word0 (in_chan.attr_word0),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_code      (out_chan.chunk_code),
  .out_last      (out_chan.last_chunk)
);
